FILE: src/round_robin_list_interleaver_unit_assert.svh
// Assertion macros used by the interleaver datapath.
`ifndef ROUND_ROBIN_LIST_INTERLEAVER_UNIT_ASSERT_SVH
`define ROUND_ROBIN_LIST_INTERLEAVER_UNIT_ASSERT_SVH

// Check a condition in the same cycle as its trigger.
`define RRLI_ASSERT_NOW(label, clk, rst, trig, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cond)) \
      else $error(msg);

// Check a condition in the cycle after its trigger.
`define RRLI_ASSERT_NEXT(label, clk, rst, trig, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) \
      else $error(msg);

`endif

FILE: src/rrli_pkg.sv
// Shared constants, codes and handshake structs for the list interleaver.
`timescale 1ns / 1ps
package rrli_pkg;

   localparam int NUM_LISTS   = 4;
   localparam int LIST_DEPTH  = 16;
   localparam int VALUE_WIDTH = 32;

   localparam int LIST_W = (NUM_LISTS > 1) ? $clog2(NUM_LISTS) : 1;
   localparam int POS_W  = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
   localparam int CNT_W  = $clog2(LIST_DEPTH + 1);
   localparam int ADDR_W = $clog2(NUM_LISTS * LIST_DEPTH);

   // Fixed widths of the request and response fields
   localparam int CMD_W    = 2;
   localparam int IDX_W    = 2;
   localparam int DATA_W   = 32;
   localparam int STATUS_W = 3;
   localparam int SRC_W    = 2;

   typedef enum logic [CMD_W-1:0] {
      CMD_APPEND = 2'd0,
      CMD_NEXT   = 2'd1,
      CMD_CLEAR  = 2'd2
   } rrli_cmd_code_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_LOADED    = 3'd0,
      STATUS_DELIVERED = 3'd1,
      STATUS_EXHAUSTED = 3'd2,
      STATUS_FULL      = 3'd3,
      STATUS_CLEARED   = 3'd4
   } rrli_status_type;

   // Controller to datapath
   typedef struct packed {
      logic accept;   // request taken this cycle
      logic deliver;  // fetched element goes to the response register
   } rrli_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic out_free; // response register empty or draining
      logic is_next;  // pending request asks for the next element
      logic hit;      // some list still holds an unread element
   } rrli_stat_type;

endpackage

FILE: src/rrli_ctrl.sv
// Sequencing state machine of the list interleaver.
`timescale 1ns / 1ps
module rrli_ctrl
   import rrli_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  rrli_stat_type stat,
   output rrli_cmd_type  cmd
);

   typedef enum logic {
      S_IDLE,
      S_FETCH
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in    = state_ff;
      req_tready  = 1'b0;
      cmd.accept  = 1'b0;
      cmd.deliver = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_tready = stat.out_free;
            cmd.accept = req_tvalid && stat.out_free;
            if (cmd.accept && stat.is_next && stat.hit) begin
               state_in = S_FETCH;
            end
         end
         S_FETCH: begin
            // memory word is in the read register; wait for room at the output
            cmd.deliver = stat.out_free;
            if (stat.out_free) begin
               state_in = S_IDLE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

FILE: src/rrli_datapath.sv
// List counters, element memory, round-robin pick and response register.
`timescale 1ns / 1ps
`include "round_robin_list_interleaver_unit_assert.svh"
module rrli_datapath
   import rrli_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  rrli_cmd_type               cmd,
   output rrli_stat_type              stat,
   input  logic [CMD_W-1:0]           req_command,
   input  logic [IDX_W-1:0]           req_list_index,
   input  logic signed [DATA_W-1:0]   req_value,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [STATUS_W-1:0]        rsp_status,
   output logic signed [DATA_W-1:0]   rsp_element,
   output logic [SRC_W-1:0]           rsp_source_list
);

   logic [CNT_W-1:0]       fill_ff [NUM_LISTS];
   logic [CNT_W-1:0]       fill_in [NUM_LISTS];
   logic [CNT_W-1:0]       read_ff [NUM_LISTS];
   logic [CNT_W-1:0]       read_in [NUM_LISTS];
   logic [LIST_W-1:0]      turn_ff, turn_in;
   logic [VALUE_WIDTH-1:0] store_mem [NUM_LISTS * LIST_DEPTH];
   logic [VALUE_WIDTH-1:0] rd_data_ff;
   logic [LIST_W-1:0]      src_hold_ff;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]    status_ff, status_in;
   logic [DATA_W-1:0]      element_ff, element_in;
   logic [SRC_W-1:0]       source_ff, source_in;

   logic [NUM_LISTS-1:0]   live;
   logic                   hit;
   logic [LIST_W-1:0]      pick;
   logic [LIST_W-1:0]      load_list;
   logic                   idx_ok;
   logic                   list_full;
   logic                   do_write, do_read, write_out;
   logic [ADDR_W-1:0]      wr_addr, rd_addr;
   logic                   clear_accept, all_empty;

   always_comb begin
      for (int i = 0; i < NUM_LISTS; i++) begin
         live[i] = read_ff[i] < fill_ff[i];
      end
   end

   // first live list at or after the turn pointer, in cyclic order
   always_comb begin
      logic [LIST_W:0] slot;
      hit  = 1'b0;
      pick = '0;
      slot = '0;
      for (int n = NUM_LISTS - 1; n >= 0; n--) begin
         slot = {1'b0, turn_ff} + (LIST_W + 1)'(n);
         if (slot >= (LIST_W + 1)'(NUM_LISTS)) begin
            slot = slot - (LIST_W + 1)'(NUM_LISTS);
         end
         if (live[slot[LIST_W-1:0]]) begin
            hit  = 1'b1;
            pick = slot[LIST_W-1:0];
         end
      end
   end

   assign idx_ok    = 32'(req_list_index) < NUM_LISTS;
   assign load_list = LIST_W'(req_list_index);
   assign list_full = fill_ff[load_list] >= CNT_W'(LIST_DEPTH);
   assign wr_addr   = ADDR_W'(load_list * LIST_DEPTH) + ADDR_W'(fill_ff[load_list][POS_W-1:0]);
   assign rd_addr   = ADDR_W'(pick * LIST_DEPTH) + ADDR_W'(read_ff[pick][POS_W-1:0]);

   assign stat.out_free = !rsp_valid_ff || rsp_ready;
   assign stat.is_next  = req_command == CMD_NEXT;
   assign stat.hit      = hit;

   always_comb begin
      fill_in      = fill_ff;
      read_in      = read_ff;
      turn_in      = turn_ff;
      do_write     = 1'b0;
      do_read      = 1'b0;
      write_out    = 1'b0;
      status_in    = status_ff;
      element_in   = element_ff;
      source_in    = source_ff;
      if (cmd.accept) begin
         write_out  = 1'b1;
         element_in = '0;
         source_in  = '0;
         unique case (req_command)
            CMD_APPEND: begin
               source_in = SRC_W'(req_list_index);
               if (idx_ok && !list_full) begin
                  do_write           = 1'b1;
                  fill_in[load_list] = fill_ff[load_list] + 1'b1;
                  status_in          = STATUS_LOADED;
               end else begin
                  status_in = STATUS_FULL;
               end
            end
            CMD_NEXT: begin
               status_in = STATUS_EXHAUSTED;
               if (hit) begin
                  // result is written later from the fetch state, once the word is read
                  write_out     = 1'b0;
                  do_read       = 1'b1;
                  read_in[pick] = read_ff[pick] + 1'b1;
                  turn_in       = (pick == LIST_W'(NUM_LISTS - 1)) ? '0 : pick + 1'b1;
               end
            end
            CMD_CLEAR: begin
               for (int i = 0; i < NUM_LISTS; i++) begin
                  fill_in[i] = '0;
                  read_in[i] = '0;
               end
               turn_in   = '0;
               status_in = STATUS_CLEARED;
            end
            default: begin
               status_in = STATUS_EXHAUSTED;
            end
         endcase
      end else if (cmd.deliver) begin
         write_out  = 1'b1;
         status_in  = STATUS_DELIVERED;
         element_in = DATA_W'(signed'(rd_data_ff));
         source_in  = SRC_W'(src_hold_ff);
      end
      if (write_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_LISTS; i++) begin
            fill_ff[i] <= '0;
            read_ff[i] <= '0;
         end
         turn_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         fill_ff      <= fill_in;
         read_ff      <= read_in;
         turn_ff      <= turn_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      status_ff  <= status_in;
      element_ff <= element_in;
      source_ff  <= source_in;
      if (do_read) begin
         src_hold_ff <= pick;
      end
   end

   // element memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (do_write) begin
         store_mem[wr_addr] <= VALUE_WIDTH'(req_value);
      end
      if (do_read) begin
         rd_data_ff <= store_mem[rd_addr];
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = status_ff;
   assign rsp_element     = element_ff;
   assign rsp_source_list = source_ff;

   assign clear_accept = cmd.accept && req_command == CMD_CLEAR;
   assign all_empty    = turn_ff == '0 && live == '0;

   `RRLI_ASSERT_NOW(a_no_overwrite, clock, reset, write_out, stat.out_free, "response overwritten")
   `RRLI_ASSERT_NOW(a_one_source, clock, reset, cmd.deliver, !cmd.accept, "accept during fetch")
   `RRLI_ASSERT_NEXT(a_clear_empties, clock, reset, clear_accept, all_empty, "clear left state")

endmodule

FILE: src/round_robin_list_interleaver_unit.sv
// Top level of the round-robin list interleaver: ports, field packing, wiring.
`timescale 1ns / 1ps
// Append, clear and exhausted requests answer in the cycle after acceptance; a next
// request that finds an element answers once the response register is free, after the
// registered read of the element memory between pick and response. One request per
// cycle while the response register is free or draining, but none during that read.
// Reset (synchronous, active high) empties all lists, returns the turn to list 0
// and drops any pending response; the element memory keeps its contents.
module round_robin_list_interleaver_unit
   import rrli_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // [1:0] list_index, [33:2] value, [39:34] zero
   input  logic [1:0]  req_tuser,   // [1:0] command
   // response channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // [31:0] element, [33:32] source_list, [39:34] zero
   output logic [2:0]  rsp_tuser    // [2:0] status
);

   rrli_cmd_type               cmd;
   rrli_stat_type              stat;
   logic [IDX_W-1:0]           req_list_index;
   logic signed [DATA_W-1:0]   req_value;
   logic [STATUS_W-1:0]        rsp_status;
   logic signed [DATA_W-1:0]   rsp_element;
   logic [SRC_W-1:0]           rsp_source_list;

   // Unpack the request fields; the command travels on tuser.
   assign req_list_index = req_tdata[IDX_W-1:0];
   assign req_value      = req_tdata[IDX_W+DATA_W-1:IDX_W];

   // The controller takes a request whenever the response register is free or
   // draining, and holds the request side off while a memory read is in flight.
   rrli_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   // The datapath owns the per-list fill and read counters, the turn pointer,
   // the element memory and the response register.
   rrli_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .stat            (stat),
      .req_command     (req_tuser),
      .req_list_index  (req_list_index),
      .req_value       (req_value),
      .rsp_valid       (rsp_tvalid),
      .rsp_ready       (rsp_tready),
      .rsp_status      (rsp_status),
      .rsp_element     (rsp_element),
      .rsp_source_list (rsp_source_list)
   );

   // Pack the response; pad tdata with zeros up to whole bytes.
   assign rsp_tdata = {6'd0, rsp_source_list, rsp_element};
   assign rsp_tuser = rsp_status;

endmodule

FILE: bench/tb.sv
// Self-checking bench for the round-robin list interleaver: directed and random requests.
`timescale 1ns / 1ps
module tb
   import rrli_pkg::*;
();

   // Command code that the block leaves unused; it must answer as exhausted
   localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;
   localparam int RANDOM_REQUESTS = 1500;
   localparam int MAX_REPORTS     = 10;
   localparam int SETTLE_CYCLES   = 10;

   typedef struct packed {
      logic [CMD_W-1:0]  cmd;
      logic [IDX_W-1:0]  list_index;
      logic [DATA_W-1:0] value;
      logic              hold_off;   // wait for every response before sending
   } request_type;

   typedef struct packed {
      rrli_status_type   status;
      logic [DATA_W-1:0] element;
      logic [SRC_W-1:0]  source_list;
   } result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata = '0;   // [1:0] list_index, [33:2] value, [39:34] zero
   logic [1:0]  req_tuser = '0;   // [1:0] command
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;        // [31:0] element, [33:32] source_list, [39:34] zero
   logic [2:0]  rsp_tuser;        // [2:0] status

   request_type pending_req [$];
   result_type  expected_rsp [$];

   // Shadow state of the lists, kept in step with accepted requests
   logic [DATA_W-1:0] list_store [NUM_LISTS][LIST_DEPTH];
   logic [CNT_W-1:0]  fill_count [NUM_LISTS];
   logic [CNT_W-1:0]  read_pos   [NUM_LISTS];
   logic [LIST_W-1:0] turn;

   int unsigned n_requests  = 0;
   int unsigned n_responses = 0;
   int unsigned n_errors    = 0;
   int unsigned n_pauses    = 0;
   int unsigned status_seen [8];

   int unsigned burst_left = 0;
   int unsigned gap_left   = 0;
   int unsigned stall_mode = 0;
   int unsigned mode_left  = 0;
   int unsigned tick       = 0;

   round_robin_list_interleaver_unit u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Work out the answer to one request and advance the shadow lists.
   // Appends fill a list up to its depth; a next request scans from the turn
   // pointer, takes the first list with unread entries and moves the turn past it.
   function automatic result_type interleave_step(logic [CMD_W-1:0]  cmd,
                                                  logic [IDX_W-1:0]  idx,
                                                  logic [DATA_W-1:0] val);
      result_type  r;
      int unsigned li;
      logic        found;
      r.status      = STATUS_EXHAUSTED;
      r.element     = '0;
      r.source_list = '0;
      found         = 1'b0;
      case (cmd)
         CMD_APPEND: begin
            r.source_list = idx;
            // an index beyond the last list is refused just like a full list
            if (idx >= NUM_LISTS || fill_count[idx] >= LIST_DEPTH) begin
               r.status = STATUS_FULL;
            end else begin
               list_store[idx][fill_count[idx]] = val;
               fill_count[idx] = fill_count[idx] + 1'b1;
               r.status = STATUS_LOADED;
            end
         end
         CMD_NEXT: begin
            for (int n = 0; n < NUM_LISTS; n++) begin
               li = (int'(turn) + n) % NUM_LISTS;
               if (!found && read_pos[li] < fill_count[li]) begin
                  found         = 1'b1;
                  r.status      = STATUS_DELIVERED;
                  r.element     = list_store[li][read_pos[li]];
                  r.source_list = SRC_W'(li);
                  read_pos[li]  = read_pos[li] + 1'b1;
                  turn          = LIST_W'((li + 1) % NUM_LISTS);
               end
            end
         end
         CMD_CLEAR: begin
            for (int k = 0; k < NUM_LISTS; k++) begin
               fill_count[k] = '0;
               read_pos[k]   = '0;
            end
            turn     = '0;
            r.status = STATUS_CLEARED;
         end
         default: begin
            // spare command: no state change, answered as exhausted
         end
      endcase
      return r;
   endfunction

   function automatic void add_request(logic [CMD_W-1:0]  cmd,
                                       logic [IDX_W-1:0]  idx,
                                       logic [DATA_W-1:0] val,
                                       logic              hold);
      request_type q;
      q.cmd        = cmd;
      q.list_index = idx;
      q.value      = val;
      q.hold_off   = hold;
      if (hold) n_pauses++;
      pending_req.insert(pending_req.size(), q);
   endfunction

   // Mostly random data, now and then one of the extreme words
   function automatic logic [DATA_W-1:0] pick_value();
      case ($urandom_range(0, 11))
         0:       return 32'h8000_0000;
         1:       return 32'h7FFF_FFFF;
         2:       return 32'hFFFF_FFFF;
         3:       return 32'h0000_0000;
         default: return $urandom;
      endcase
   endfunction

   // Driver: present requests in bursts with random gaps; a request marked
   // hold_off is held back until every earlier request has been answered.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         gap_left   <= 0;
         burst_left <= 0;
      end else if (!req_tvalid || req_tready) begin
         if (gap_left != 0) begin
            gap_left   <= gap_left - 1;
            req_tvalid <= 1'b0;
         end else if (pending_req.size() != 0 &&
                      !(pending_req[0].hold_off &&
                        (req_tvalid || n_requests != n_responses))) begin
            req_tvalid <= 1'b1;
            req_tdata  <= {6'b0, pending_req[0].value, pending_req[0].list_index};
            req_tuser  <= pending_req[0].cmd;
            pending_req.delete(0);
            if (burst_left <= 1) begin
               burst_left <= $urandom_range(1, 24);
               gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            end else begin
               burst_left <= burst_left - 1;
            end
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Receiver: switch between stall patterns, each held for a random stretch
   always @(posedge clock) begin
      tick <= tick + 1;
      if (mode_left == 0) begin
         stall_mode <= $urandom_range(0, 3);
         mode_left  <= $urandom_range(20, 200);
      end else begin
         mode_left <= mode_left - 1;
      end
      case (stall_mode)
         0:       rsp_tready <= 1'b1;
         1:       rsp_tready <= ($urandom_range(0, 3) != 0);
         2:       rsp_tready <= ($urandom_range(0, 2) == 0);
         default: rsp_tready <= (tick % 8) < 5;
      endcase
   end

   // Monitor: predict on every accepted request, check every accepted response
   always @(posedge clock) begin
      result_type want;
      if (reset) begin
         for (int k = 0; k < NUM_LISTS; k++) begin
            fill_count[k] = '0;
            read_pos[k]   = '0;
         end
         turn = '0;
      end else begin
         if (req_tvalid && req_tready) begin
            want = interleave_step(req_tuser, req_tdata[1:0], req_tdata[33:2]);
            status_seen[want.status]++;
            expected_rsp.insert(expected_rsp.size(), want);
            n_requests <= n_requests + 1;
         end
         if (rsp_tvalid && rsp_tready) begin
            n_responses <= n_responses + 1;
            if (expected_rsp.size() == 0) begin
               n_errors++;
               if (n_errors <= MAX_REPORTS)
                  $display("response %0d with nothing expected: status %0d data %h",
                           n_responses, rsp_tuser, rsp_tdata);
            end else begin
               want = expected_rsp[0];
               expected_rsp.delete(0);
               if (rsp_tuser != want.status || rsp_tdata[31:0] != want.element ||
                   rsp_tdata[33:32] != want.source_list) begin
                  n_errors++;
                  if (n_errors <= MAX_REPORTS) begin
                     $display("response %0d mismatch: status exp %0d got %0d",
                              n_responses, want.status, rsp_tuser);
                     $display("   element exp %h got %h, list exp %0d got %0d",
                              want.element, rsp_tdata[31:0], want.source_list,
                              rsp_tdata[33:32]);
                  end
               end
            end
         end
      end
   end

   // Stimulus and end of run
   initial begin
      int unsigned seg_len;
      int unsigned append_pct;
      int unsigned roll;
      int unsigned made;
      logic [IDX_W-1:0] favourite;

      // Directed: extreme values, rotation, exhaustion, spare command,
      // reload of an exhausted list, clear, then one list filled past its depth
      add_request(CMD_APPEND, 2'd0, 32'h8000_0000, 1'b0);
      add_request(CMD_APPEND, 2'd3, 32'h7FFF_FFFF, 1'b0);
      add_request(CMD_NEXT,   2'd2, 32'h0000_0000, 1'b0);
      add_request(CMD_NEXT,   2'd1, 32'hFFFF_FFFF, 1'b0);
      add_request(CMD_NEXT,   2'd0, 32'h0000_0000, 1'b0);
      add_request(CMD_SPARE,  2'd3, 32'hFFFF_FFFF, 1'b0);
      add_request(CMD_APPEND, 2'd3, 32'hFFFF_FFFF, 1'b0);
      add_request(CMD_NEXT,   2'd0, 32'h0000_0000, 1'b0);
      add_request(CMD_CLEAR,  2'd1, 32'h5555_AAAA, 1'b0);
      for (int k = 0; k < LIST_DEPTH; k++)
         add_request(CMD_APPEND, 2'd1, (k % 2) ? 32'hA5A5_5A5A : 32'h0000_0000 + k, k == 0);
      add_request(CMD_APPEND, 2'd1, 32'h1234_5678, 1'b0);

      // Random: segments that lean towards loading or towards draining, so that
      // lists both fill up and run dry; a few clears and spare commands as noise
      made = 0;
      while (made < RANDOM_REQUESTS) begin
         seg_len    = $urandom_range(8, 60);
         favourite  = IDX_W'($urandom_range(0, NUM_LISTS - 1));
         case ($urandom_range(0, 3))
            0:       append_pct = 25;
            1:       append_pct = 50;
            2:       append_pct = 75;
            default: append_pct = 95;
         endcase
         for (int k = 0; k < seg_len; k++) begin
            roll = $urandom_range(0, 99);
            if (roll < 2)
               add_request(CMD_CLEAR, IDX_W'($urandom), $urandom, 1'b0);
            else if (roll < 4)
               add_request(CMD_SPARE, IDX_W'($urandom), $urandom, 1'b0);
            else if (roll < 4 + append_pct * 96 / 100)
               add_request(CMD_APPEND,
                           ($urandom_range(0, 1) == 0) ? favourite : IDX_W'($urandom),
                           pick_value(), k == 0 && $urandom_range(0, 7) == 0);
            else
               add_request(CMD_NEXT, IDX_W'($urandom), $urandom,
                           k == 0 && $urandom_range(0, 7) == 0);
         end
         made += seg_len;
      end

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Hold until every request is out and answered, then let the block settle
      @(negedge clock);
      while (pending_req.size() != 0 || req_tvalid || expected_rsp.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (expected_rsp.size() != 0) begin
         n_errors += expected_rsp.size();
         $display("%0d responses never arrived", expected_rsp.size());
      end

      $display("Sent %0d requests (%0d after waiting for a full drain), checked %0d responses.",
               n_requests, n_pauses, n_responses);
      $display("Stored %0d, refused full %0d, handed out %0d, exhausted %0d, cleared %0d;",
               status_seen[STATUS_LOADED], status_seen[STATUS_FULL],
               status_seen[STATUS_DELIVERED], status_seen[STATUS_EXHAUSTED],
               status_seen[STATUS_CLEARED]);
      $display("%0d errors.", n_errors);
      if (n_errors == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   // Guard against a hung handshake
   initial begin
      #2_000_000;
      $display("Simulation FAILED");
      $finish;
   end

endmodule
